### rtl/tmv_pkg.sv
package tmv_pkg;

  // Configuration port
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 1'b1;

  // Default sizing
  localparam int unsigned MAX_FEATURES_DEF = 65536;
  localparam int unsigned MAX_ROWS_DEF     = 65536;

  // Datapath widths
  localparam int unsigned LANES  = 4;
  localparam int unsigned CODE_W = 2;
  localparam int unsigned ACT_W  = 8;
  localparam int unsigned TERM_W = ACT_W + 1;   // negated -128 needs one more bit
  localparam int unsigned LSUM_W = TERM_W + 2;  // sum of four terms
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned ROW_W  = 16;

  // Ternary weight codes
  localparam logic [CODE_W-1:0] CODE_NEG = 2'd0;
  localparam logic [CODE_W-1:0] CODE_POS = 2'd2;

  // Word handed from the lane stage to the accumulate stage
  typedef struct packed {
    logic signed [LSUM_W-1:0] lane_sum;
    logic                     row_end;
    logic [ROW_W-1:0]         row_idx;
    logic                     last_row;
  } s1_word_t;

endpackage

### rtl/tmv_lane.sv
module tmv_lane (
  input  logic [tmv_pkg::CODE_W-1:0]        code_i,
  input  logic signed [tmv_pkg::ACT_W-1:0]  act_i,
  input  logic                              en_i,
  output logic signed [tmv_pkg::TERM_W-1:0] term_o
);
  import tmv_pkg::*;

  logic signed [TERM_W-1:0] act_ext;

  assign act_ext = TERM_W'(act_i);

  // Ternary multiply: -a, +a or nothing; masked lanes give zero
  always_comb begin
    term_o = '0;
    if (en_i) begin
      case (code_i)
        CODE_NEG: term_o = -act_ext;
        CODE_POS: term_o = act_ext;
        default:  term_o = '0;
      endcase
    end
  end

endmodule

### rtl/tmv_merge.sv
module tmv_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s1_valid_i,
  input  tmv_pkg::s1_word_t               s1_word_i,
  output logic                            s1_take_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [tmv_pkg::ACC_W-1:0] dot_sum_o,
  output logic [tmv_pkg::ROW_W-1:0]       row_index_o,
  output logic                            last_row_o
);
  import tmv_pkg::*;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W:0]   sum_wide;
  logic signed [ACC_W-1:0] sum_sat;
  logic                    out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0] dot_sum_q;
  logic [ROW_W-1:0]        row_index_q;
  logic                    last_row_q;
  logic                    out_free;
  logic                    emit;

  // Saturating add of the lane sum into the row accumulator
  assign sum_wide = (ACC_W+1)'(acc_q) + (ACC_W+1)'(s1_word_i.lane_sum);

  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  // A row-ending word needs a free output slot; other words always pass
  assign out_free  = !out_valid_q || !out_stall_i;
  assign s1_take_o = s1_valid_i && (!s1_word_i.row_end || out_free);
  assign emit      = s1_take_o && s1_word_i.row_end;

  always_comb begin
    acc_d = acc_q;
    if (s1_take_o) begin
      acc_d = s1_word_i.row_end ? '0 : sum_sat;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      dot_sum_q   <= sum_sat;
      row_index_q <= s1_word_i.row_idx;
      last_row_q  <= s1_word_i.last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = dot_sum_q;
  assign row_index_o = row_index_q;
  assign last_row_o  = last_row_q;

endmodule

### rtl/ternary_int8_matvec.sv
// Ternary-weight int8 matrix-vector product.
//
// Input channel (in_valid_i / in_stall_o): each word carries one packed
// weight byte (four 2-bit codes, bits 7:6 first) and the four signed
// activations act0..act3 that pair with them. A row takes
// ceil(feature_count/4) words; lanes past feature_count are ignored.
// Output channel (out_valid_o / out_stall_i): one word per row with the
// saturated 24-bit sum, the row index and a last-row flag.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 = feature_count, 1 = row_count); write only while the block is idle.
// Throughput is one input word per cycle unless a row-ending word waits on
// a stalled output: four add/subtract lanes feed a single accumulator.
// A row's sum reaches the output by way of the lane register and then
// the output register, which holds it while the output is stalled.
// Reset clears the accumulator, the feature and row positions and sets
// feature_count to 4 and row_count to 1. While the output is stalled,
// words that do not end a row keep flowing; a row-ending word waits in the
// lane register and the input stalls behind it.
module ternary_int8_matvec #(
  parameter int unsigned MAX_FEATURES = tmv_pkg::MAX_FEATURES_DEF,
  parameter int unsigned MAX_ROWS     = tmv_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tmv_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        weight_byte_i,
  input  logic signed [tmv_pkg::ACT_W-1:0]  act0_i,
  input  logic signed [tmv_pkg::ACT_W-1:0]  act1_i,
  input  logic signed [tmv_pkg::ACT_W-1:0]  act2_i,
  input  logic signed [tmv_pkg::ACT_W-1:0]  act3_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tmv_pkg::ACC_W-1:0]  dot_sum_o,
  output logic [tmv_pkg::ROW_W-1:0]         row_index_o,
  output logic                              last_row_o
);
  import tmv_pkg::*;

  localparam int unsigned FCW = $clog2(MAX_FEATURES + 1);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [FCW-1:0] fc_q;
  logic [RCW-1:0] rc_q;
  logic [FCW-1:0] pos_q, pos_d;
  logic [RPW-1:0] row_q, row_d;
  logic           s1_valid_q, s1_valid_d;
  s1_word_t       s1_word_q, s1_word_d;
  logic           s1_accept;
  logic           s2_take;

  logic signed [ACT_W-1:0]  act  [LANES];
  logic signed [TERM_W-1:0] term [LANES];
  logic [FCW:0]             pos_ext, fc_ext;
  logic                     row_end;
  logic [RCW-1:0]           row_p1;
  logic                     last;
  logic signed [LSUM_W-1:0] lane_sum;

  // Configuration registers, held already clamped to their legal ranges
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FCW'(LANES);
      rc_q <= RCW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FEATURE_COUNT: begin
          if (cfg_data_i == '0) begin
            fc_q <= FCW'(1);
          end else if (cfg_data_i > CFG_W'(MAX_FEATURES)) begin
            fc_q <= FCW'(MAX_FEATURES);
          end else begin
            fc_q <= FCW'(cfg_data_i);
          end
        end
        REG_ROW_COUNT: begin
          if (cfg_data_i == '0) begin
            rc_q <= RCW'(1);
          end else if (cfg_data_i > CFG_W'(MAX_ROWS)) begin
            rc_q <= RCW'(MAX_ROWS);
          end else begin
            rc_q <= RCW'(cfg_data_i);
          end
        end
        default: ;
      endcase
    end
  end

  assign act[0] = act0_i;
  assign act[1] = act1_i;
  assign act[2] = act2_i;
  assign act[3] = act3_i;

  assign pos_ext = (FCW+1)'(pos_q);
  assign fc_ext  = (FCW+1)'(fc_q);

  // Four ternary lanes; a lane counts only while its feature is in the row
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tmv_lane u_lane (
      .code_i (weight_byte_i[CODE_W*(LANES-1-l) +: CODE_W]),
      .act_i  (act[l]),
      .en_i   ((pos_ext + (FCW+1)'(l)) < fc_ext),
      .term_o (term[l])
    );
  end

  assign lane_sum = LSUM_W'(term[0]) + LSUM_W'(term[1])
                  + LSUM_W'(term[2]) + LSUM_W'(term[3]);

  // Row and feature position tracking
  assign row_end = (pos_ext + (FCW+1)'(LANES)) >= fc_ext;
  assign row_p1  = RCW'(row_q) + RCW'(1);
  assign last    = row_p1 >= rc_q;

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    if (s1_accept) begin
      if (row_end) begin
        pos_d = '0;
        row_d = last ? '0 : RPW'(row_p1);
      end else begin
        pos_d = pos_q + FCW'(LANES);
      end
    end
  end

  // Lane stage register
  assign in_stall_o = s1_valid_q && !s2_take;
  assign s1_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_word_d          = s1_word_q;
    s1_valid_d         = s1_valid_q;
    if (s2_take) begin
      s1_valid_d = 1'b0;
    end
    if (s1_accept) begin
      s1_valid_d         = 1'b1;
      s1_word_d.lane_sum = lane_sum;
      s1_word_d.row_end  = row_end;
      s1_word_d.row_idx  = ROW_W'(row_q);
      s1_word_d.last_row = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_word_q <= s1_word_d;
  end

  // Accumulate, saturate and hold the row result
  tmv_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .s1_word_i   (s1_word_q),
    .s1_take_o   (s2_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dot_sum_o   (dot_sum_o),
    .row_index_o (row_index_o),
    .last_row_o  (last_row_o)
  );

endmodule
